// ===== hdl/lcdr_pkg.sv =====
`default_nettype none
package lcdr_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 144;
	localparam int SPRITE_COUNT  = 40;

	localparam int FRAME_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int MAP_DEPTH    = 2048;
	localparam int TILE_DEPTH   = 256 * 64;
	localparam int MAP_AW       = $clog2(MAP_DEPTH);
	localparam int TILE_AW      = $clog2(TILE_DEPTH);
	localparam int LBG_AW       = $clog2(SCREEN_WIDTH);
	localparam int FRM_AW       = $clog2(FRAME_PIXELS);
	localparam int SPR_AW       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int CLR_DEPTH    = (FRAME_PIXELS > TILE_DEPTH) ? FRAME_PIXELS : TILE_DEPTH;
	localparam int CLR_W        = $clog2(CLR_DEPTH);

	localparam logic [9:0] OAM_CYCLES    = 10'd80;
	localparam logic [9:0] XFER_CYCLES   = 10'd172;
	localparam logic [9:0] HBLANK_CYCLES = 10'd204;
	localparam logic [9:0] LINE_CYCLES   = 10'd456;
	localparam logic [7:0] LAST_LINE     = 8'd153;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_MAP   = 3'd1;
	localparam logic [2:0] OP_TILE  = 3'd2;
	localparam logic [2:0] OP_SPR   = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [2:0] CFG_CTRL  = 3'd0;
	localparam logic [2:0] CFG_SCY   = 3'd1;
	localparam logic [2:0] CFG_SCX   = 3'd2;
	localparam logic [2:0] CFG_IRQEN = 3'd3;
	localparam logic [2:0] CFG_PAL0  = 3'd4;
	localparam logic [2:0] CFG_PAL1  = 3'd5;
	localparam logic [2:0] CFG_PAL2  = 3'd6;
	localparam logic [2:0] CFG_PAL3  = 3'd7;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_TICK,
		K_MAP,
		K_TILE,
		K_SPR,
		K_READ,
		K_NOP
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PIX,
		S_BG_MAP,
		S_BG_TILE,
		S_BG_WR,
		S_SPR_RD,
		S_SPR_CHK,
		S_COL_RD,
		S_COL_WR
	} st_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         cycles;
		logic [10:0]        map_address;
		logic [7:0]         tile_number;
		logic [2:0]         tile_row;
		logic [2:0]         tile_col;
		logic [1:0]         pixel_value;
		logic [5:0]         sprite_index;
		logic signed [8:0]  sprite_x;
		logic signed [8:0]  sprite_y;
		logic [2:0]         sprite_flags;
		logic [14:0]        pixel_index;
	} item_t;

	typedef struct packed {
		logic [7:0]         tile;
		logic signed [8:0]  x;
		logic signed [8:0]  y;
		logic [2:0]         flags;
	} spr_t;

endpackage
`default_nettype wire

// ===== hdl/lcdr_front.sv =====
`default_nettype none
module lcdr_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           op,
	input  wire logic [7:0]           cycles,
	input  wire logic [10:0]          map_address,
	input  wire logic [7:0]           tile_number,
	input  wire logic [2:0]           tile_row,
	input  wire logic [2:0]           tile_col,
	input  wire logic [1:0]           pixel_value,
	input  wire logic [5:0]           sprite_index,
	input  wire logic signed [8:0]    sprite_x,
	input  wire logic signed [8:0]    sprite_y,
	input  wire logic [2:0]           sprite_flags,
	input  wire logic [14:0]          pixel_index,
	input  wire logic                 clearing,
	output logic                      q_valid,
	output lcdr_pkg::item_t           q_item,
	input  wire logic                 q_pop
);

	lcdr_pkg::item_t itm;
	lcdr_pkg::item_t q_mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;

	always_comb begin
		itm.cycles       = cycles;
		itm.map_address  = map_address;
		itm.tile_number  = tile_number;
		itm.tile_row     = tile_row;
		itm.tile_col     = tile_col;
		itm.pixel_value  = pixel_value;
		itm.sprite_index = sprite_index;
		itm.sprite_x     = sprite_x;
		itm.sprite_y     = sprite_y;
		itm.sprite_flags = sprite_flags;
		itm.pixel_index  = pixel_index;
		case (op)
			lcdr_pkg::OP_TICK: itm.kind = lcdr_pkg::K_TICK;
			lcdr_pkg::OP_MAP:  itm.kind = lcdr_pkg::K_MAP;
			lcdr_pkg::OP_TILE: itm.kind = lcdr_pkg::K_TILE;
			lcdr_pkg::OP_SPR: begin
				itm.kind = (32'(sprite_index) < lcdr_pkg::SPRITE_COUNT) ?
					lcdr_pkg::K_SPR : lcdr_pkg::K_NOP;
			end
			lcdr_pkg::OP_READ: begin
				itm.kind = (32'(pixel_index) < lcdr_pkg::FRAME_PIXELS) ?
					lcdr_pkg::K_READ : lcdr_pkg::K_NOP;
			end
			default: itm.kind = lcdr_pkg::K_NOP;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2) && !clearing;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= itm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lcdr_back.sv =====
`default_nettype none
module lcdr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               q_valid,
	input  wire lcdr_pkg::item_t    q_item,
	output logic                    q_pop,
	output logic                    clearing,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              mode,
	output logic [7:0]              line,
	output logic                    vblank_irq,
	output logic                    frame_ready,
	output logic [31:0]             pixel_color
);

	localparam int LA = lcdr_pkg::LBG_AW;
	localparam int FA = lcdr_pkg::FRM_AW;
	localparam int SA = lcdr_pkg::SPR_AW;

	logic [7:0]  ctrl_q, scy_q, scx_q;
	logic        irqen_q;
	logic [31:0] pal_q [4];

	lcdr_pkg::st_t   st_q, st_d;
	lcdr_pkg::mode_t mode_q, mode_d;
	logic [9:0]      mclk_q, mclk_d, mclk_sum;
	logic [7:0]      line_q, line_d, line_inc;
	logic [LA-1:0]   pix_q, pix_d, px_q, px_d;
	logic [SA-1:0]   spr_q, spr_d;
	logic [2:0]      col_q, col_d, row_q, row_d;
	logic [lcdr_pkg::CLR_W-1:0] clr_q, clr_d;
	logic [FA-1:0]   rbase_q, rbase_d;
	lcdr_pkg::spr_t  sp_q, sp_d, ent;

	logic        out_valid_q, ld, ld_irq, ld_rdy;
	logic [31:0] ld_color;
	logic [1:0]  res_mode_q;
	logic [7:0]  res_line_q;
	logic        res_irq_q, res_rdy_q;
	logic [31:0] res_color_q;
	logic        out_free;

	logic [7:0]  map_mem [lcdr_pkg::MAP_DEPTH];
	logic [1:0]  tile_mem [lcdr_pkg::TILE_DEPTH];
	logic [1:0]  frm_mem [lcdr_pkg::FRAME_PIXELS];
	logic [1:0]  lbg_mem [lcdr_pkg::SCREEN_WIDTH];
	lcdr_pkg::spr_t spr_mem [lcdr_pkg::SPRITE_COUNT];
	logic [lcdr_pkg::SPRITE_COUNT-1:0] spr_vld_q;

	logic                             map_we;
	logic [lcdr_pkg::MAP_AW-1:0]      map_wa, map_ra;
	logic [7:0]                       map_wd, map_rd_q;
	logic                             tile_we;
	logic [lcdr_pkg::TILE_AW-1:0]     tile_wa, tile_ra;
	logic [1:0]                       tile_wd, tile_rd_q;
	logic                             frm_we;
	logic [FA-1:0]                    frm_wa, frm_ra;
	logic [1:0]                       frm_wd, frm_rd_q;
	logic                             lbg_we;
	logic [1:0]                       lbg_rd_q;
	logic                             spr_we;
	logic [SA-1:0]                    spr_wa;
	lcdr_pkg::spr_t                   spr_wd, spr_rd_q;
	logic                             spr_vld_rd_q;

	logic [7:0]  yy, xx;
	logic [9:0]  diff, pxs;
	logic        hit, on_screen, draw;
	logic [2:0]  tc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			scy_q   <= '0;
			scx_q   <= '0;
			irqen_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				pal_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				lcdr_pkg::CFG_CTRL:  ctrl_q   <= cfg_data[7:0];
				lcdr_pkg::CFG_SCY:   scy_q    <= cfg_data[7:0];
				lcdr_pkg::CFG_SCX:   scx_q    <= cfg_data[7:0];
				lcdr_pkg::CFG_IRQEN: irqen_q  <= cfg_data[0];
				lcdr_pkg::CFG_PAL0:  pal_q[0] <= cfg_data;
				lcdr_pkg::CFG_PAL1:  pal_q[1] <= cfg_data;
				lcdr_pkg::CFG_PAL2:  pal_q[2] <= cfg_data;
				lcdr_pkg::CFG_PAL3:  pal_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign clearing = (st_q == lcdr_pkg::S_CLEAR);
	assign mclk_sum = mclk_q + {2'b00, q_item.cycles};
	assign line_inc = line_q + 8'd1;
	assign yy       = line_q + scy_q;
	assign xx       = scx_q + 8'(pix_q);
	assign ent      = spr_vld_rd_q ? spr_rd_q : '0;
	assign diff     = {2'b00, line_q} - {ent.y[8], ent.y};
	assign hit      = !diff[9] && (diff[8:3] == 6'd0);
	assign pxs      = {sp_q.x[8], sp_q.x} + {7'd0, col_q};
	assign on_screen = !pxs[9] && (pxs[8:0] < 9'(lcdr_pkg::SCREEN_WIDTH));
	assign tc       = sp_q.flags[0] ? ~col_q : col_q;
	assign draw     = !(sp_q.flags[2] && (lbg_rd_q != 2'd0)) && (tile_rd_q != 2'd0);

	assign map_ra = {ctrl_q[3], yy[7:3], xx[7:3]};
	assign frm_ra = FA'(q_item.pixel_index);

	always_comb begin
		st_d     = st_q;
		mode_d   = mode_q;
		mclk_d   = mclk_q;
		line_d   = line_q;
		pix_d    = pix_q;
		px_d     = px_q;
		spr_d    = spr_q;
		col_d    = col_q;
		row_d    = row_q;
		clr_d    = clr_q;
		rbase_d  = rbase_q;
		sp_d     = sp_q;
		q_pop    = 1'b0;
		ld       = 1'b0;
		ld_irq   = 1'b0;
		ld_rdy   = 1'b0;
		ld_color = '0;
		map_we   = 1'b0;
		map_wa   = q_item.map_address;
		map_wd   = q_item.tile_number;
		tile_we  = 1'b0;
		tile_wa  = {q_item.tile_number, q_item.tile_row, q_item.tile_col};
		tile_wd  = q_item.pixel_value;
		tile_ra  = {sp_q.tile, row_q, tc};
		frm_we   = 1'b0;
		frm_wa   = rbase_q + FA'(pix_q);
		frm_wd   = tile_rd_q;
		lbg_we   = 1'b0;
		spr_we   = 1'b0;
		spr_wa   = SA'(q_item.sprite_index);
		spr_wd   = {q_item.tile_number, q_item.sprite_x, q_item.sprite_y,
			q_item.sprite_flags};
		case (st_q)
			lcdr_pkg::S_CLEAR: begin
				map_we  = (32'(clr_q) < lcdr_pkg::MAP_DEPTH);
				map_wa  = clr_q[lcdr_pkg::MAP_AW-1:0];
				map_wd  = '0;
				tile_we = (32'(clr_q) < lcdr_pkg::TILE_DEPTH);
				tile_wa = clr_q[lcdr_pkg::TILE_AW-1:0];
				tile_wd = '0;
				frm_we  = (32'(clr_q) < lcdr_pkg::FRAME_PIXELS);
				frm_wa  = FA'(clr_q);
				frm_wd  = '0;
				clr_d   = clr_q + 1'b1;
				if (clr_q == lcdr_pkg::CLR_W'(lcdr_pkg::CLR_DEPTH - 1)) begin
					st_d = lcdr_pkg::S_IDLE;
				end
			end
			lcdr_pkg::S_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					ld    = 1'b1;
					case (q_item.kind)
						lcdr_pkg::K_TICK: begin
							mclk_d = mclk_sum;
							case (mode_q)
								lcdr_pkg::MODE_OAM: begin
									if (mclk_sum >= lcdr_pkg::OAM_CYCLES) begin
										mclk_d = '0;
										mode_d = lcdr_pkg::MODE_XFER;
									end
								end
								lcdr_pkg::MODE_XFER: begin
									if (mclk_sum >= lcdr_pkg::XFER_CYCLES) begin
										mclk_d = '0;
										mode_d = lcdr_pkg::MODE_HBLANK;
										if (ctrl_q[0] &&
											32'(line_q) < lcdr_pkg::SCREEN_HEIGHT) begin
											ld      = 1'b0;
											pix_d   = '0;
											rbase_d = FA'(32'(line_q) * lcdr_pkg::SCREEN_WIDTH);
											st_d    = lcdr_pkg::S_BG_MAP;
										end
									end
								end
								lcdr_pkg::MODE_HBLANK: begin
									if (mclk_sum >= lcdr_pkg::HBLANK_CYCLES) begin
										mclk_d = '0;
										line_d = line_inc;
										if (32'(line_inc) == lcdr_pkg::SCREEN_HEIGHT) begin
											mode_d = lcdr_pkg::MODE_VBLANK;
											ld_rdy = 1'b1;
											ld_irq = irqen_q;
										end else begin
											mode_d = lcdr_pkg::MODE_OAM;
										end
									end
								end
								default: begin
									if (mclk_sum >= lcdr_pkg::LINE_CYCLES) begin
										mclk_d = '0;
										line_d = line_inc;
										if (line_inc > lcdr_pkg::LAST_LINE) begin
											mode_d = lcdr_pkg::MODE_OAM;
											line_d = '0;
										end
									end
								end
							endcase
						end
						lcdr_pkg::K_MAP:  map_we  = 1'b1;
						lcdr_pkg::K_TILE: tile_we = 1'b1;
						lcdr_pkg::K_SPR:  spr_we  = 1'b1;
						lcdr_pkg::K_READ: begin
							ld   = 1'b0;
							st_d = lcdr_pkg::S_PIX;
						end
						default: ;
					endcase
				end
			end
			lcdr_pkg::S_PIX: begin
				ld       = 1'b1;
				ld_color = pal_q[frm_rd_q];
				st_d     = lcdr_pkg::S_IDLE;
			end
			lcdr_pkg::S_BG_MAP: begin
				st_d = lcdr_pkg::S_BG_TILE;
			end
			lcdr_pkg::S_BG_TILE: begin
				tile_ra = {map_rd_q, yy[2:0], xx[2:0]};
				st_d    = lcdr_pkg::S_BG_WR;
			end
			lcdr_pkg::S_BG_WR: begin
				frm_we = 1'b1;
				lbg_we = 1'b1;
				if (pix_q == LA'(lcdr_pkg::SCREEN_WIDTH - 1)) begin
					spr_d = '0;
					st_d  = lcdr_pkg::S_SPR_RD;
				end else begin
					pix_d = pix_q + 1'b1;
					st_d  = lcdr_pkg::S_BG_MAP;
				end
			end
			lcdr_pkg::S_SPR_RD: begin
				st_d = lcdr_pkg::S_SPR_CHK;
			end
			lcdr_pkg::S_SPR_CHK: begin
				if (hit) begin
					sp_d  = ent;
					row_d = ent.flags[1] ? ~diff[2:0] : diff[2:0];
					col_d = '0;
					st_d  = lcdr_pkg::S_COL_RD;
				end else if (spr_q == SA'(lcdr_pkg::SPRITE_COUNT - 1)) begin
					ld   = 1'b1;
					st_d = lcdr_pkg::S_IDLE;
				end else begin
					spr_d = spr_q + 1'b1;
					st_d  = lcdr_pkg::S_SPR_RD;
				end
			end
			lcdr_pkg::S_COL_RD, lcdr_pkg::S_COL_WR: begin
				if (st_q == lcdr_pkg::S_COL_RD && on_screen) begin
					px_d = LA'(pxs);
					st_d = lcdr_pkg::S_COL_WR;
				end else begin
					if (st_q == lcdr_pkg::S_COL_WR) begin
						frm_we = draw;
						frm_wa = rbase_q + FA'(px_q);
						frm_wd = tile_rd_q;
					end
					if (col_q != 3'd7) begin
						col_d = col_q + 3'd1;
						st_d  = lcdr_pkg::S_COL_RD;
					end else if (spr_q == SA'(lcdr_pkg::SPRITE_COUNT - 1)) begin
						ld   = 1'b1;
						st_d = lcdr_pkg::S_IDLE;
					end else begin
						spr_d = spr_q + 1'b1;
						st_d  = lcdr_pkg::S_SPR_RD;
					end
				end
			end
			default: st_d = lcdr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lcdr_pkg::S_CLEAR;
			mode_q      <= lcdr_pkg::MODE_HBLANK;
			mclk_q      <= '0;
			line_q      <= '0;
			pix_q       <= '0;
			spr_q       <= '0;
			col_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			spr_vld_q   <= '0;
		end else begin
			st_q   <= st_d;
			mode_q <= mode_d;
			mclk_q <= mclk_d;
			line_q <= line_d;
			pix_q  <= pix_d;
			spr_q  <= spr_d;
			col_q  <= col_d;
			clr_q  <= clr_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (spr_we) begin
				spr_vld_q[spr_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		px_q    <= px_d;
		row_q   <= row_d;
		rbase_q <= rbase_d;
		sp_q    <= sp_d;
		if (ld) begin
			res_mode_q  <= mode_d;
			res_line_q  <= line_d;
			res_irq_q   <= ld_irq;
			res_rdy_q   <= ld_rdy;
			res_color_q <= ld_color;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (tile_we) begin
			tile_mem[tile_wa] <= tile_wd;
		end
		tile_rd_q <= tile_mem[tile_ra];
	end

	always_ff @(posedge clk) begin
		if (frm_we) begin
			frm_mem[frm_wa] <= frm_wd;
		end
		frm_rd_q <= frm_mem[frm_ra];
	end

	always_ff @(posedge clk) begin
		if (lbg_we) begin
			lbg_mem[pix_q] <= tile_rd_q;
		end
		lbg_rd_q <= lbg_mem[LA'(pxs)];
	end

	always_ff @(posedge clk) begin
		if (spr_we) begin
			spr_mem[spr_wa] <= spr_wd;
		end
		spr_rd_q     <= spr_mem[spr_q];
		spr_vld_rd_q <= spr_vld_q[spr_q];
	end

	assign out_valid   = out_valid_q;
	assign mode        = res_mode_q;
	assign line        = res_line_q;
	assign vblank_irq  = res_irq_q;
	assign frame_ready = res_rdy_q;
	assign pixel_color = res_color_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop) else $error("item taken during clearing pass");
	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid_q || out_ready)) else $error("result slot overrun");
	a_line_max: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= lcdr_pkg::LAST_LINE) else $error("line counter out of range");
	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == lcdr_pkg::S_BG_WR |-> mode_q == lcdr_pkg::MODE_HBLANK)
		else $error("render outside hblank");
	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lcdr_pkg::MODE_VBLANK |-> 32'(line_q) >= lcdr_pkg::SCREEN_HEIGHT)
		else $error("vblank on visible line");

endmodule
`default_nettype wire

// ===== hdl/lcd_mode_timing_and_line_render_top.sv =====
// LCD mode timing and scanline renderer.
// Input words arrive on in_valid/in_ready with the op and its fields; each
// word yields exactly one result word on out_valid/out_ready carrying mode,
// line, the vblank pulses and, for pixel reads, the palette color.
// The user must write registers through cfg_we/cfg_index/cfg_data while
// idle; the block does not enforce it. A front part classifies words into
// a two-entry queue; the back part runs timing, store writes, pixel reads
// and line rendering in order. Ticks, store writes and unknown ops are
// handled in the idle state, the result registered as the word leaves the
// queue; a pixel read waits for the registered frame store read port.
// A tick that leaves transfer with the background enabled renders the line
// first: map read, tile read and write states per background pixel, read
// and check states per sprite entry, and for a sprite on the line a column
// read state per column plus a write state per column on screen.
// After reset a clearing pass zeroes the map, tile and frame stores;
// in_ready stays low during it.
// When the receiver stalls the result is held in the output register while
// up to two more words are queued, then in_ready drops.
`default_nettype none
module lcd_mode_timing_and_line_render_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        op,
	input  wire logic [7:0]        cycles,
	input  wire logic [10:0]       map_address,
	input  wire logic [7:0]        tile_number,
	input  wire logic [2:0]        tile_row,
	input  wire logic [2:0]        tile_col,
	input  wire logic [1:0]        pixel_value,
	input  wire logic [5:0]        sprite_index,
	input  wire logic signed [8:0] sprite_x,
	input  wire logic signed [8:0] sprite_y,
	input  wire logic [2:0]        sprite_flags,
	input  wire logic [14:0]       pixel_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             mode,
	output logic [7:0]             line,
	output logic                   vblank_irq,
	output logic                   frame_ready,
	output logic [31:0]            pixel_color
);

	logic            q_valid;
	logic            q_pop;
	logic            clearing;
	lcdr_pkg::item_t q_item;

	lcdr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.cycles       (cycles),
		.map_address  (map_address),
		.tile_number  (tile_number),
		.tile_row     (tile_row),
		.tile_col     (tile_col),
		.pixel_value  (pixel_value),
		.sprite_index (sprite_index),
		.sprite_x     (sprite_x),
		.sprite_y     (sprite_y),
		.sprite_flags (sprite_flags),
		.pixel_index  (pixel_index),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	lcdr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mode        (mode),
		.line        (line),
		.vblank_irq  (vblank_irq),
		.frame_ready (frame_ready),
		.pixel_color (pixel_color)
	);

endmodule
`default_nettype wire
